>>> src/ustc_pkg.sv
// Shared types and constants for the seconds-to-calendar converter.
// No dependencies; used by ustc_ctrl, ustc_dp and unix_seconds_to_calendar.
package ustc_pkg;

  typedef struct packed {
    logic [31:0] unix_seconds;
    logic        time_known;
  } in_t;

  typedef struct packed {
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_24;
    logic [3:0]  hour_12;
    logic        is_pm;
    logic [2:0]  weekday;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
  } out_t;

  // Datapath commands issued by the controller
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL,
    CMD_REM,
    CMD_YEAR,
    CMD_MONTH,
    CMD_PUBLISH
  } cmd_t;

  typedef struct packed {
    logic last_round;
    logic year_done;
    logic month_done;
  } stat_t;

  // Division rounds: seconds, minutes, hours, weekday
  localparam logic [1:0] RND_SEC  = 2'd0;
  localparam logic [1:0] RND_MIN  = 2'd1;
  localparam logic [1:0] RND_HOUR = 2'd2;
  localparam logic [1:0] RND_WDAY = 2'd3;

  // Reciprocal constants: x/60 = ((x>>2)*M15)>>34, x/24 = ((x>>3)*M3)>>33,
  // x/7 = (x*M7)>>20 for x below 2^17
  localparam logic [31:0] M15 = 32'h4444_4445;
  localparam logic [31:0] M3  = 32'hAAAA_AAAB;
  localparam logic [31:0] M7  = 32'd149797;

  localparam logic [5:0] SEC_PER_MIN  = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR = 6'd60;
  localparam logic [5:0] HOUR_PER_DAY = 6'd24;
  localparam logic [5:0] DAY_PER_WEEK = 6'd7;
  localparam logic [31:0] EPOCH_WDAY_OFS = 32'd4; // 1970-01-01 was a Thursday

  localparam logic [11:0] EPOCH_YEAR = 12'd1970;
  // Only century year in range that is not a leap year
  localparam logic [11:0] NOLEAP_CENTURY = 12'd2100;
  localparam logic [8:0]  DAYS_LEAP = 9'd366;
  localparam logic [8:0]  DAYS_NORM = 9'd365;
  localparam logic [3:0]  MON_FEB = 4'd1;
  localparam logic [3:0]  MON_DEC = 4'd11;

  function automatic logic is_leap(input logic [11:0] yr);
    is_leap = (yr[1:0] == 2'b00) && (yr != NOLEAP_CENTURY);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: month_days = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   month_days = 5'd30;
      MON_FEB:                                   month_days = leap ? 5'd29 : 5'd28;
      default:                                   month_days = 5'd31;
    endcase
  endfunction

endpackage

>>> src/unix_seconds_to_calendar.sv
// Unix seconds to calendar date and time of day.
// Input channel: in_valid/in_stall carry in_data (seconds count and a
//   time-known flag; when the flag is clear the count is taken as zero).
// Output channel: out_valid/out_stall carry out_data (second, minute,
//   24h and 12h hour, PM flag, weekday with Sunday = 1, year, month, day).
// One transaction in gives exactly one transaction out. Items are handled
// one at a time: an accept step, four reciprocal-multiply divisions (by
// 60, 60, 24, 7), each a multiply step then a remainder step, a walk year
// by year from 1970, a walk month by month, and a load of the output
// register, which waits while the register still holds an unaccepted result.
// The year walk dominates the time taken. in_stall is low only while idle.
// The output register holds a finished result while out_stall is high and
// the next transaction may already be accepted and worked on; it waits
// before publishing until the register is free.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid. There is no configuration and no stored state between items.
// Depends on ustc_pkg, ustc_ctrl and ustc_dp.
module unix_seconds_to_calendar (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ustc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ustc_pkg::out_t out_data
);

  ustc_pkg::cmd_t  cmd;
  ustc_pkg::stat_t stat;

  ustc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ustc_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

>>> src/ustc_ctrl.sv
// Controller FSM for the seconds-to-calendar converter.
// Sequences datapath commands; uses ustc_pkg.
module ustc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  ustc_pkg::stat_t stat,
  output ustc_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_REM,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = ustc_pkg::CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = ustc_pkg::CMD_LOAD;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd       = ustc_pkg::CMD_MUL;
        state_nxt = S_REM;
      end
      S_REM: begin
        cmd       = ustc_pkg::CMD_REM;
        state_nxt = stat.last_round ? S_YEAR : S_MUL;
      end
      S_YEAR: begin
        cmd = ustc_pkg::CMD_YEAR;
        if (stat.year_done) state_nxt = S_MONTH;
      end
      S_MONTH: begin
        cmd = ustc_pkg::CMD_MONTH;
        if (stat.month_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd       = ustc_pkg::CMD_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd == ustc_pkg::CMD_PUBLISH) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> src/ustc_dp.sv
// Datapath for the seconds-to-calendar converter: reciprocal divider,
// year and month walk, output register. Uses ustc_pkg.
module ustc_dp (
  input  logic            clk,
  input  ustc_pkg::cmd_t  cmd,
  input  ustc_pkg::in_t   in_data,
  output ustc_pkg::stat_t stat,
  output ustc_pkg::out_t  out_data
);

  logic [31:0] val_r;
  logic [63:0] prod_r;
  logic [1:0]  step_r;
  logic [5:0]  sec_r, min_r;
  logic [4:0]  h24_r;
  logic [2:0]  wday_r;
  logic [15:0] days_r;
  logic [11:0] year_r;
  logic [3:0]  mon_r;
  ustc_pkg::out_t out_r;

  logic [31:0] mul_op, mul_k, dvd, quo;
  logic [5:0]  divisor, rem;
  logic [11:0] qd_lo;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [3:0]  h12;

  // Multiplier operand and reciprocal for the current round
  always_comb begin
    dvd = val_r;
    case (step_r)
      ustc_pkg::RND_SEC, ustc_pkg::RND_MIN: begin
        mul_op  = {2'b00, val_r[31:2]};
        mul_k   = ustc_pkg::M15;
        quo     = 32'(prod_r >> 34);
        divisor = ustc_pkg::SEC_PER_MIN;
      end
      ustc_pkg::RND_HOUR: begin
        mul_op  = {3'b000, val_r[31:3]};
        mul_k   = ustc_pkg::M3;
        quo     = 32'(prod_r >> 33);
        divisor = ustc_pkg::HOUR_PER_DAY;
      end
      default: begin
        dvd     = val_r + ustc_pkg::EPOCH_WDAY_OFS;
        mul_op  = dvd;
        mul_k   = ustc_pkg::M7;
        quo     = 32'(prod_r >> 20);
        divisor = ustc_pkg::DAY_PER_WEEK;
      end
    endcase
  end

  // remainder is below 60, so six low bits suffice
  assign qd_lo = quo[5:0] * divisor;
  assign rem   = dvd[5:0] - qd_lo[5:0];

  assign leap = ustc_pkg::is_leap(year_r);
  assign ylen = leap ? ustc_pkg::DAYS_LEAP : ustc_pkg::DAYS_NORM;
  assign mlen = ustc_pkg::month_days(mon_r, leap);

  assign stat.last_round = (step_r == ustc_pkg::RND_WDAY);
  assign stat.year_done  = (days_r < {7'd0, ylen});
  assign stat.month_done = (days_r < {11'd0, mlen}) || (mon_r == ustc_pkg::MON_DEC);

  always_comb begin
    if (h24_r == 5'd0)       h12 = 4'd12;
    else if (h24_r > 5'd12)  h12 = 4'(h24_r - 5'd12);
    else                     h12 = h24_r[3:0];
  end

  always_ff @(posedge clk) begin
    case (cmd)
      ustc_pkg::CMD_LOAD: begin
        val_r  <= in_data.time_known ? in_data.unix_seconds : 32'd0;
        step_r <= ustc_pkg::RND_SEC;
        year_r <= ustc_pkg::EPOCH_YEAR;
        mon_r  <= 4'd0;
      end
      ustc_pkg::CMD_MUL: prod_r <= mul_op * mul_k;
      ustc_pkg::CMD_REM: begin
        step_r <= step_r + 2'd1;
        case (step_r)
          ustc_pkg::RND_SEC: begin
            sec_r <= rem;
            val_r <= quo;
          end
          ustc_pkg::RND_MIN: begin
            min_r <= rem;
            val_r <= quo;
          end
          ustc_pkg::RND_HOUR: begin
            h24_r <= rem[4:0];
            val_r <= quo;
          end
          default: begin
            wday_r <= rem[2:0] + 3'd1;
            days_r <= val_r[15:0];
          end
        endcase
      end
      ustc_pkg::CMD_YEAR: begin
        if (!stat.year_done) begin
          days_r <= days_r - {7'd0, ylen};
          year_r <= year_r + 12'd1;
        end
      end
      ustc_pkg::CMD_MONTH: begin
        if (!stat.month_done) begin
          days_r <= days_r - {11'd0, mlen};
          mon_r  <= mon_r + 4'd1;
        end
      end
      ustc_pkg::CMD_PUBLISH: begin
        out_r.second_of_minute <= sec_r;
        out_r.minute_of_hour   <= min_r;
        out_r.hour_24          <= h24_r;
        out_r.hour_12          <= h12;
        out_r.is_pm            <= (h24_r >= 5'd12);
        out_r.weekday          <= wday_r;
        out_r.year             <= year_r;
        out_r.month            <= mon_r + 4'd1;
        out_r.day_of_month     <= days_r[4:0] + 5'd1;
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule
